/* rtl/core/rwl_pkg.sv */
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and codes for the recursive reader/writer lock manager.
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int OP_W   = 2;
    localparam int TID_W  = 4;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK = 2'd2;

    localparam logic [STAT_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_WAIT     = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] ST_ERROR    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FREE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHARED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXCLUSIVE = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_cmd_t;

endpackage

/* rtl/core/rwl_datapath.sv */
// ----------------------------------------------------------------------------
// rwl_datapath
// Request register, per-thread read count store, writer state and the
// result word register.
// ----------------------------------------------------------------------------
module rwl_datapath #(
    parameter int THREAD_COUNT = 16,
    parameter int DEPTH_BITS   = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rwl_pkg::ctl_cmd_t           cmd,
    input  logic [rwl_pkg::OP_W-1:0]    opcode,
    input  logic [rwl_pkg::TID_W-1:0]   thread_id,
    output logic [rwl_pkg::STAT_W-1:0]  status,
    output logic                        wake,
    output logic [rwl_pkg::MODE_W-1:0]  lock_mode
);
    import rwl_pkg::*;

    localparam int TID_SPAN    = 1 << TID_W;
    localparam int STORE_DEPTH = (THREAD_COUNT < TID_SPAN) ? THREAD_COUNT : TID_SPAN;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int RT_W        = $clog2(STORE_DEPTH + 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    logic [OP_W-1:0]       op_reg;
    logic [TID_W-1:0]      tid_reg;
    logic [DEPTH_BITS-1:0] rd_reg [STORE_DEPTH];
    logic [RT_W-1:0]       rt_reg;
    logic [DEPTH_BITS-1:0] wd_reg;
    logic [TID_W-1:0]      wo_reg;
    logic [STAT_W-1:0]     status_reg;
    logic                  wake_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic [IDX_W-1:0]      idx;
    logic                  tid_ok;
    logic                  owns;
    logic [DEPTH_BITS-1:0] cur_rd;
    logic                  rd_we;
    logic [DEPTH_BITS-1:0] rd_next;
    logic [RT_W-1:0]       rt_next;
    logic [DEPTH_BITS-1:0] wd_next;
    logic [TID_W-1:0]      wo_next;
    logic [STAT_W-1:0]     status_next;
    logic                  wake_next;
    logic [MODE_W-1:0]     mode_next;

    assign idx    = tid_reg[IDX_W-1:0];
    assign tid_ok = (32'(tid_reg) < 32'(THREAD_COUNT));
    assign cur_rd = tid_ok ? rd_reg[idx] : '0;
    assign owns   = (wd_reg != '0) && (wo_reg == tid_reg);

    always_comb
    begin
        rd_we       = 1'b0;
        rd_next     = cur_rd;
        rt_next     = rt_reg;
        wd_next     = wd_reg;
        wo_next     = wo_reg;
        status_next = ST_ERROR;
        wake_next   = 1'b0;
        if (tid_ok)
        begin
            case (op_reg) inside
                OP_READ, OP_WRITE:
                begin
                    if (owns)
                    begin
                        if (wd_reg != DEPTH_MAX)
                        begin
                            wd_next     = wd_reg + DEPTH_BITS'(1);
                            status_next = ST_GRANTED;
                        end
                    end
                    else if (wd_reg != '0)
                    begin
                        status_next = ST_WAIT;
                    end
                    else if (op_reg == OP_READ)
                    begin
                        if (cur_rd != DEPTH_MAX)
                        begin
                            rd_we       = 1'b1;
                            rd_next     = cur_rd + DEPTH_BITS'(1);
                            status_next = ST_GRANTED;
                            if (cur_rd == '0)
                            begin
                                rt_next = rt_reg + RT_W'(1);
                            end
                        end
                    end
                    else if ((rt_reg == '0) || ((rt_reg == RT_W'(1)) && (cur_rd != '0)))
                    begin
                        wo_next     = tid_reg;
                        wd_next     = DEPTH_BITS'(1);
                        status_next = ST_GRANTED;
                    end
                    else
                    begin
                        status_next = ST_WAIT;
                    end
                end
                OP_UNLOCK:
                begin
                    if (owns)
                    begin
                        wd_next     = wd_reg - DEPTH_BITS'(1);
                        status_next = ST_RELEASED;
                        wake_next   = (wd_reg == DEPTH_BITS'(1));
                    end
                    else if (cur_rd != '0)
                    begin
                        rd_we       = 1'b1;
                        rd_next     = cur_rd - DEPTH_BITS'(1);
                        status_next = ST_RELEASED;
                        if ((cur_rd == DEPTH_BITS'(1)) && (rt_reg != '0))
                        begin
                            rt_next = rt_reg - RT_W'(1);
                        end
                        wake_next = (rt_next <= RT_W'(1));
                    end
                end
                default:
                begin
                    status_next = ST_ERROR;
                end
            endcase
        end

        if (wd_next != '0)
        begin
            mode_next = MODE_EXCLUSIVE;
        end
        else if (rt_next != '0)
        begin
            mode_next = MODE_SHARED;
        end
        else
        begin
            mode_next = MODE_FREE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            tid_reg <= thread_id;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            wake_reg   <= wake_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                rd_reg[i] <= '0;
            end
            rt_reg <= '0;
            wd_reg <= '0;
            wo_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (rd_we)
            begin
                rd_reg[idx] <= rd_next;
            end
            rt_reg <= rt_next;
            wd_reg <= wd_next;
            wo_reg <= wo_next;
        end
    end

    assign status    = status_reg;
    assign wake      = wake_reg;
    assign lock_mode = mode_reg;

endmodule

/* rtl/core/rwl_ctrl.sv */
// ----------------------------------------------------------------------------
// rwl_ctrl
// Request sequencer: takes a word, evaluates it once the result slot is
// free, and tracks the result word's valid flag.
// ----------------------------------------------------------------------------
module rwl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output rwl_pkg::ctl_cmd_t cmd
);
    import rwl_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/recursive_rw_lock_manager_top.sv */
// ----------------------------------------------------------------------------
// recursive_rw_lock_manager_top
// Recursive reader/writer lock manager for one shared resource.
// ----------------------------------------------------------------------------
// Each request word (read lock, write lock, unlock from a numbered thread)
// gets exactly one result word: granted, must wait, released or error, plus
// a wake flag and the lock mode after the request. S_IDLE takes a request
// word; S_EXEC reads the thread's count entry, updates the writer state and
// loads the result register, then returns to S_IDLE for the next word. A
// result held by out_stall delays evaluation of the following request until
// the result register frees up. The read count store resets to zero at once
// with the reader total and writer state; no clearing pass is needed.
module recursive_rw_lock_manager_top #(
    parameter int THREAD_COUNT = 16,
    parameter int DEPTH_BITS   = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rwl_pkg::OP_W-1:0]    opcode,
    input  logic [rwl_pkg::TID_W-1:0]   thread_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rwl_pkg::STAT_W-1:0]  status,
    output logic                        wake,
    output logic [rwl_pkg::MODE_W-1:0]  lock_mode
);
    import rwl_pkg::*;

    ctl_cmd_t cmd;

    rwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rwl_datapath #(
        .THREAD_COUNT (THREAD_COUNT),
        .DEPTH_BITS   (DEPTH_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .opcode    (opcode),
        .thread_id (thread_id),
        .status    (status),
        .wake      (wake),
        .lock_mode (lock_mode)
    );

endmodule

/* rtl/core/rwl_checker.sv */
// ----------------------------------------------------------------------------
// rwl_checker
// Port-level checks for the lock manager, bound to the top level.
// ----------------------------------------------------------------------------
module rwl_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [rwl_pkg::STAT_W-1:0]  status,
    input  logic                        wake,
    input  logic [rwl_pkg::MODE_W-1:0]  lock_mode
);
    import rwl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(wake)
            && $stable(lock_mode))
        else $error("stalled result word changed");

    a_wake_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_RELEASED) |-> !wake)
        else $error("wake raised without a release");

    a_grant_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_GRANTED) |-> (lock_mode != MODE_FREE))
        else $error("grant left the lock free");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while a request is in evaluation");

endmodule

bind recursive_rw_lock_manager_top rwl_checker u_rwl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .wake      (wake),
    .lock_mode (lock_mode)
);
